FILE: design/csl_pkg.sv
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types, codes and character helpers of the C-subset lexer.
// ----------------------------------------------------------------------------
package csl_pkg;

  typedef enum logic [4:0] {
    TK_ADD      = 5'd0,
    TK_SUB      = 5'd1,
    TK_MUL      = 5'd2,
    TK_DIV      = 5'd3,
    TK_ASSIGN   = 5'd4,
    TK_EQ       = 5'd5,
    TK_NOT      = 5'd6,
    TK_NE       = 5'd7,
    TK_GT       = 5'd8,
    TK_GE       = 5'd9,
    TK_LT       = 5'd10,
    TK_LE       = 5'd11,
    TK_AMP      = 5'd12,
    TK_LBRACE   = 5'd13,
    TK_RBRACE   = 5'd14,
    TK_LPAREN   = 5'd15,
    TK_RPAREN   = 5'd16,
    TK_COMMA    = 5'd17,
    TK_SEMI     = 5'd18,
    TK_INT_LIT  = 5'd19,
    TK_IDENT    = 5'd20,
    TK_RETURN   = 5'd21,
    TK_IF       = 5'd22,
    TK_FOR      = 5'd23,
    TK_INT_TYPE = 5'd24
  } csl_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_UNEXPECTED = 2'd1,
    ERR_TOO_LONG   = 2'd2
  } csl_err_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_NUM   = 3'd1,
    MODE_IDENT = 3'd2,
    MODE_PEQ   = 3'd3,
    MODE_PNOT  = 3'd4,
    MODE_PGT   = 3'd5,
    MODE_PLT   = 3'd6,
    MODE_ERR   = 3'd7
  } csl_mode_e;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_SINGLE,
    CLS_PAIR,
    CLS_DIGIT,
    CLS_WORD,
    CLS_BAD
  } csl_class_e;

  typedef enum logic [1:0] {
    PH_LEX,
    PH_T1,
    PH_T2
  } csl_phase_e;

  // Keyword table: return, if, for, int
  localparam int unsigned KW_N = 4;

  // One queued job: an optional lexeme run, then up to two single results.
  typedef struct packed {
    logic      lex_valid;
    logic      lex_bank;
    csl_kind_e lex_kind;
    logic      t1_valid;
    csl_kind_e t1_kind;
    logic      t2_valid;
    csl_kind_e t2_kind;
    csl_err_e  t2_err;
  } csl_cmd_t;

  function automatic csl_class_e csl_class(input logic [7:0] b);
    csl_class_e c;
    c = CLS_BAD;
    if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
      c = CLS_SPACE;
    end else if (b == "+" || b == "-" || b == "*" || b == "/" || b == "&" ||
                 b == "{" || b == "}" || b == "(" || b == ")" || b == "," ||
                 b == ";") begin
      c = CLS_SINGLE;
    end else if (b == "=" || b == "!" || b == ">" || b == "<") begin
      c = CLS_PAIR;
    end else if (b >= "0" && b <= "9") begin
      c = CLS_DIGIT;
    end else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_") begin
      c = CLS_WORD;
    end
    return c;
  endfunction

  function automatic csl_kind_e csl_single_kind(input logic [7:0] b);
    csl_kind_e k;
    case (b)
      "+":     k = TK_ADD;
      "-":     k = TK_SUB;
      "*":     k = TK_MUL;
      "/":     k = TK_DIV;
      "&":     k = TK_AMP;
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      ",":     k = TK_COMMA;
      default: k = TK_SEMI;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] csl_kw_len(input logic [1:0] k);
    logic [2:0] n;
    case (k)
      2'd0:    n = 3'd6;
      2'd1:    n = 3'd2;
      default: n = 3'd3;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] csl_kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [47:0] w;
    logic [7:0]  c;
    case (k)
      2'd0:    w = "return";
      2'd1:    w = {"if", 32'h0};
      2'd2:    w = {"for", 24'h0};
      default: w = {"int", 24'h0};
    endcase
    c = 8'h00;
    if (pos < 3'd6) begin
      c = w[47 - 8 * pos -: 8];
    end
    return c;
  endfunction

endpackage

FILE: design/csl_if.sv
// ----------------------------------------------------------------------------
// csl_in_if / csl_out_if
// Valid/ready channels of the lexer: source bytes in, token words out.
// ----------------------------------------------------------------------------
interface csl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink   (input valid, in_byte, end_of_input, output ready);
endinterface

interface csl_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] tok_kind;
  logic [7:0] lexeme_char;
  logic       char_valid;
  logic       token_end;
  logic [1:0] error_code;
  logic       step_end;

  modport source (output valid, tok_kind, lexeme_char, char_valid, token_end,
                  error_code, step_end, input ready);
  modport sink   (input valid, tok_kind, lexeme_char, char_valid, token_end,
                  error_code, step_end, output ready);
endinterface

FILE: design/csl_ram.sv
// ----------------------------------------------------------------------------
// csl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module csl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/csl_cmd_fifo.sv
// ----------------------------------------------------------------------------
// csl_cmd_fifo
// Short job queue between the scanner front end and the result back end.
// ----------------------------------------------------------------------------
module csl_cmd_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      cnt_q;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign dout_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wrap_inc(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= wrap_inc(rptr_q);
      end
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

endmodule

FILE: design/csl_front.sv
// ----------------------------------------------------------------------------
// csl_front
// Scanner front end: classify each byte, track the scan mode, buffer lexeme
// characters into a two-bank store and queue output jobs.
// ----------------------------------------------------------------------------
module csl_front #(
  parameter int unsigned LEXEME_BUF_LEN = 32,
  localparam int unsigned LW = $clog2(LEXEME_BUF_LEN)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  csl_in_if.sink            in_i,
  output csl_pkg::csl_cmd_t cmd_o,
  output logic [LW-1:0]     cmd_len_o,
  output logic              cmd_push_o,
  input  logic              cmd_full_i,
  input  logic              lex_done_i,
  output logic              ram_we_o,
  output logic [LW:0]       ram_waddr_o,
  output logic [7:0]        ram_wdata_o
);

  csl_pkg::csl_mode_e mode_q, mode_d;
  logic [LW-1:0]      len_q, len_d;
  logic [csl_pkg::KW_N-1:0] kw_q, kw_d;
  logic               wbank_q;
  logic [1:0]         busy_q;

  csl_pkg::csl_cmd_t  cmd;
  csl_pkg::csl_class_e cls;
  logic [7:0]         b;
  logic [7:0]         pos8;
  logic               accept, stall, has_cmd;
  logic               flush_lex, flush_pair, scan, start, cont, handoff, more;
  logic               wr_bank;
  logic [LW-1:0]      wr_idx;

  function automatic csl_pkg::csl_kind_e pair_kind(input csl_pkg::csl_mode_e m,
                                                   input logic with_eq);
    csl_pkg::csl_kind_e k;
    case (m)
      csl_pkg::MODE_PEQ:  k = with_eq ? csl_pkg::TK_EQ : csl_pkg::TK_ASSIGN;
      csl_pkg::MODE_PNOT: k = with_eq ? csl_pkg::TK_NE : csl_pkg::TK_NOT;
      csl_pkg::MODE_PGT:  k = with_eq ? csl_pkg::TK_GE : csl_pkg::TK_GT;
      default:            k = with_eq ? csl_pkg::TK_LE : csl_pkg::TK_LT;
    endcase
    return k;
  endfunction

  assign b    = in_i.in_byte;
  assign cls  = csl_pkg::csl_class(b);
  assign pos8 = 8'(len_q);

  always_comb begin
    cmd        = '0;
    mode_d     = mode_q;
    len_d      = len_q;
    kw_d       = kw_q;
    flush_lex  = 1'b0;
    flush_pair = 1'b0;
    scan       = 1'b0;
    start      = 1'b0;
    cont       = 1'b0;
    handoff    = 1'b0;
    more       = (mode_q == csl_pkg::MODE_NUM) ? (cls == csl_pkg::CLS_DIGIT) :
                 (cls == csl_pkg::CLS_DIGIT || cls == csl_pkg::CLS_WORD);

    if (mode_q != csl_pkg::MODE_ERR) begin
      if (in_i.end_of_input) begin
        flush_lex  = (mode_q == csl_pkg::MODE_NUM || mode_q == csl_pkg::MODE_IDENT);
        flush_pair = (mode_q == csl_pkg::MODE_PEQ || mode_q == csl_pkg::MODE_PNOT ||
                      mode_q == csl_pkg::MODE_PGT || mode_q == csl_pkg::MODE_PLT);
        mode_d     = csl_pkg::MODE_IDLE;
      end else begin
        case (mode_q)
          csl_pkg::MODE_NUM, csl_pkg::MODE_IDENT: begin
            if (more) begin
              if (pos8 >= 8'(LEXEME_BUF_LEN - 1)) begin
                cmd.t2_valid = 1'b1;
                cmd.t2_err   = csl_pkg::ERR_TOO_LONG;
                mode_d       = csl_pkg::MODE_ERR;
                len_d        = '0;
              end else begin
                cont = 1'b1;
              end
            end else begin
              flush_lex = 1'b1;
              scan      = 1'b1;
            end
          end
          csl_pkg::MODE_PEQ, csl_pkg::MODE_PNOT, csl_pkg::MODE_PGT,
          csl_pkg::MODE_PLT: begin
            if (b == "=") begin
              cmd.t2_valid = 1'b1;
              cmd.t2_kind  = pair_kind(mode_q, 1'b1);
              mode_d       = csl_pkg::MODE_IDLE;
            end else begin
              flush_pair = 1'b1;
              scan       = 1'b1;
            end
          end
          default: begin
            scan = 1'b1;
          end
        endcase
      end
    end

    // pending token leaves first
    if (flush_lex) begin
      handoff       = 1'b1;
      cmd.lex_valid = 1'b1;
      cmd.lex_bank  = wbank_q;
      cmd.lex_kind  = csl_pkg::TK_INT_LIT;
      if (mode_q == csl_pkg::MODE_IDENT) begin
        cmd.lex_kind = csl_pkg::TK_IDENT;
        if (kw_q[0] && pos8 == 8'd6) begin
          cmd.lex_kind = csl_pkg::TK_RETURN;
        end else if (kw_q[1] && pos8 == 8'd2) begin
          cmd.lex_kind = csl_pkg::TK_IF;
        end else if (kw_q[2] && pos8 == 8'd3) begin
          cmd.lex_kind = csl_pkg::TK_FOR;
        end else if (kw_q[3] && pos8 == 8'd3) begin
          cmd.lex_kind = csl_pkg::TK_INT_TYPE;
        end
      end
      len_d  = '0;
      mode_d = csl_pkg::MODE_IDLE;
    end
    if (flush_pair) begin
      cmd.t1_valid = 1'b1;
      cmd.t1_kind  = pair_kind(mode_q, 1'b0);
      mode_d       = csl_pkg::MODE_IDLE;
    end

    // then the byte is scanned as from idle
    if (scan) begin
      mode_d = csl_pkg::MODE_IDLE;
      case (cls)
        csl_pkg::CLS_SPACE: ;
        csl_pkg::CLS_SINGLE: begin
          cmd.t2_valid = 1'b1;
          cmd.t2_kind  = csl_pkg::csl_single_kind(b);
        end
        csl_pkg::CLS_PAIR: begin
          case (b)
            "=":     mode_d = csl_pkg::MODE_PEQ;
            "!":     mode_d = csl_pkg::MODE_PNOT;
            ">":     mode_d = csl_pkg::MODE_PGT;
            default: mode_d = csl_pkg::MODE_PLT;
          endcase
        end
        csl_pkg::CLS_DIGIT: begin
          start  = 1'b1;
          mode_d = csl_pkg::MODE_NUM;
        end
        csl_pkg::CLS_WORD: begin
          start  = 1'b1;
          mode_d = csl_pkg::MODE_IDENT;
        end
        default: begin
          cmd.t2_valid = 1'b1;
          cmd.t2_err   = csl_pkg::ERR_UNEXPECTED;
          mode_d       = csl_pkg::MODE_ERR;
        end
      endcase
    end

    // keyword prefix tracking
    if (start) begin
      len_d = LW'(1);
      for (int k = 0; k < csl_pkg::KW_N; k++) begin
        kw_d[k] = (b == csl_pkg::csl_kw_char(2'(k), 3'd0));
      end
    end else if (cont) begin
      len_d = len_q + LW'(1);
      for (int k = 0; k < csl_pkg::KW_N; k++) begin
        kw_d[k] = kw_q[k] && (pos8 < 8'(csl_pkg::csl_kw_len(2'(k)))) &&
                  (b == csl_pkg::csl_kw_char(2'(k), pos8[2:0]));
      end
    end
  end

  // a new lexeme needs a bank that the back end no longer reads
  assign has_cmd    = cmd.lex_valid | cmd.t1_valid | cmd.t2_valid;
  assign stall      = (has_cmd && cmd_full_i) ||
                      (start && (handoff ? (busy_q != 2'd0) : (busy_q == 2'd2)));
  assign in_i.ready = !stall;
  assign accept     = in_i.valid && !stall;
  assign cmd_push_o = accept && has_cmd;

  assign wr_bank     = (start && handoff) ? ~wbank_q : wbank_q;
  assign wr_idx      = start ? '0 : len_q;
  assign ram_we_o    = accept && (start || cont);
  assign ram_waddr_o = {wr_bank, wr_idx};
  assign ram_wdata_o = b;

  assign cmd_o     = cmd;
  assign cmd_len_o = len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= csl_pkg::MODE_IDLE;
      len_q   <= '0;
      kw_q    <= '0;
      wbank_q <= 1'b0;
      busy_q  <= 2'd0;
    end else begin
      if (accept) begin
        mode_q  <= mode_d;
        len_q   <= len_d;
        kw_q    <= kw_d;
        wbank_q <= wbank_q ^ handoff;
      end
      busy_q <= busy_q + 2'(accept && handoff) - 2'(lex_done_i);
    end
  end

endmodule

FILE: design/csl_back.sv
// ----------------------------------------------------------------------------
// csl_back
// Result back end: walk each queued job, read lexeme characters from the store
// and drive one token word per cycle through an output register if not stalled.
// ----------------------------------------------------------------------------
module csl_back #(
  parameter int unsigned LEXEME_BUF_LEN = 32,
  localparam int unsigned LW = $clog2(LEXEME_BUF_LEN)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csl_pkg::csl_cmd_t cmd_i,
  input  logic [LW-1:0]     cmd_len_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  output logic              lex_done_o,
  output logic              ram_re_o,
  output logic [LW:0]       ram_raddr_o,
  input  logic [7:0]        ram_rdata_i,
  csl_out_if.source         out_o
);

  csl_pkg::csl_phase_e phase_q, phase_d;
  logic [LW-1:0]       idx_q, idx_d;

  logic                sel_char, sel_t1, lex_last, last, issue, adv1;

  // read stage (RAM data arrives with it)
  logic                s1_valid_q;
  csl_pkg::csl_kind_e  s1_kind_q;
  logic                s1_char_q, s1_tend_q, s1_send_q;
  csl_pkg::csl_err_e   s1_err_q;
  csl_pkg::csl_kind_e  sel_kind;
  logic                sel_tend;
  csl_pkg::csl_err_e   sel_err;

  // output register
  logic                out_valid_q;
  csl_pkg::csl_kind_e  out_kind_q;
  logic [7:0]          out_char_q;
  logic                out_cv_q, out_tend_q, out_send_q;
  csl_pkg::csl_err_e   out_err_q;

  assign adv1  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign issue = !cmd_empty_i && (!s1_valid_q || adv1);

  always_comb begin
    sel_char = (phase_q == csl_pkg::PH_LEX) && cmd_i.lex_valid;
    sel_t1   = !sel_char && (phase_q != csl_pkg::PH_T2) && cmd_i.t1_valid;
    lex_last = (idx_q == cmd_len_i - LW'(1));
    phase_d  = phase_q;
    idx_d    = idx_q;

    if (sel_char) begin
      last     = lex_last && !cmd_i.t1_valid && !cmd_i.t2_valid;
      sel_kind = cmd_i.lex_kind;
      sel_tend = lex_last;
      sel_err  = csl_pkg::ERR_NONE;
    end else if (sel_t1) begin
      last     = !cmd_i.t2_valid;
      sel_kind = cmd_i.t1_kind;
      sel_tend = 1'b1;
      sel_err  = csl_pkg::ERR_NONE;
    end else begin
      last     = 1'b1;
      sel_kind = cmd_i.t2_kind;
      sel_tend = (cmd_i.t2_err == csl_pkg::ERR_NONE);
      sel_err  = cmd_i.t2_err;
    end

    if (last) begin
      phase_d = csl_pkg::PH_LEX;
      idx_d   = '0;
    end else if (sel_char) begin
      if (lex_last) begin
        phase_d = csl_pkg::PH_T1;
        idx_d   = '0;
      end else begin
        idx_d = idx_q + LW'(1);
      end
    end else begin
      phase_d = csl_pkg::PH_T2;
    end
  end

  assign cmd_pop_o   = issue && last;
  assign lex_done_o  = issue && sel_char && lex_last;
  assign ram_re_o    = issue && sel_char;
  assign ram_raddr_o = {cmd_i.lex_bank, idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= csl_pkg::PH_LEX;
      idx_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
      end
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (adv1) begin
        s1_valid_q <= 1'b0;
      end
      if (adv1) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_kind_q <= sel_kind;
      s1_char_q <= sel_char;
      s1_tend_q <= sel_tend;
      s1_err_q  <= sel_err;
      s1_send_q <= last;
    end
    if (adv1) begin
      out_kind_q <= (s1_err_q != csl_pkg::ERR_NONE) ? csl_pkg::TK_ADD : s1_kind_q;
      out_char_q <= s1_char_q ? ram_rdata_i : 8'h00;
      out_cv_q   <= s1_char_q;
      out_tend_q <= s1_tend_q;
      out_err_q  <= s1_err_q;
      out_send_q <= s1_send_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.tok_kind    = out_kind_q;
  assign out_o.lexeme_char = out_char_q;
  assign out_o.char_valid  = out_cv_q;
  assign out_o.token_end   = out_tend_q;
  assign out_o.error_code  = out_err_q;
  assign out_o.step_end    = out_send_q;

endmodule

FILE: design/c_subset_lexer_core.sv
// ----------------------------------------------------------------------------
// c_subset_lexer_core
// Lexical scanner for a small C subset: source bytes in, token words out.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                        | handshake
//  --------+-----+------------------------------------------------+-------------
//  in_i    | in  | in_byte[7:0], end_of_input                     | valid/ready
//  out_o   | out | tok_kind[4:0], lexeme_char[7:0], char_valid,   | valid/ready
//          |     | token_end, error_code[1:0], step_end           |
//
//  One byte is taken per cycle unless the input stalls, and one token word
//  leaves per cycle unless the output stalls; a byte that ends a lexeme of N
//  characters produces N or N+1 words, drained by the back end at one word a
//  cycle while the front keeps scanning. With the back end idle, the first
//  word of a job goes through the job queue, read stage and output register.
//  The input stalls when the byte queues a job while the job queue is full,
//  or when a byte opens a new lexeme in a bank the back end still reads.
//  Reset is asynchronous, active low, clears scan, queue and back-end state only;
//  the lexeme store is never cleared, since only written entries are read.
// ----------------------------------------------------------------------------
module c_subset_lexer_core #(
  parameter int unsigned LEXEME_BUF_LEN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  csl_in_if.sink     in_i,
  csl_out_if.source  out_o
);

  localparam int unsigned LW        = $clog2(LEXEME_BUF_LEN);
  localparam int unsigned CW        = $bits(csl_pkg::csl_cmd_t);
  localparam int unsigned QW        = CW + LW;
  localparam int unsigned RAM_DEPTH = 2 ** (LW + 1);

  // front end to queue
  csl_pkg::csl_cmd_t cmd_in;
  logic [LW-1:0]     cmd_len_in;
  logic              cmd_push, cmd_full;

  // queue to back end
  logic [QW-1:0]     q_dout;
  csl_pkg::csl_cmd_t cmd_head;
  logic [LW-1:0]     cmd_len_head;
  logic              cmd_pop, cmd_empty;

  // lexeme store ports and bank release
  logic              ram_we, ram_re, lex_done;
  logic [LW:0]       ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // Front end: classify, track scan mode, write lexeme bytes, emit jobs.
  csl_front #(
    .LEXEME_BUF_LEN(LEXEME_BUF_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cmd_o      (cmd_in),
    .cmd_len_o  (cmd_len_in),
    .cmd_push_o (cmd_push),
    .cmd_full_i (cmd_full),
    .lex_done_i (lex_done),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata)
  );

  // Job queue: decouple scanning from result draining.
  csl_cmd_fifo #(
    .WIDTH(QW),
    .DEPTH(4)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .din_i  ({cmd_len_in, cmd_in}),
    .pop_i  (cmd_pop),
    .dout_o (q_dout),
    .full_o (cmd_full),
    .empty_o(cmd_empty)
  );

  assign cmd_head     = csl_pkg::csl_cmd_t'(q_dout[CW-1:0]);
  assign cmd_len_head = q_dout[QW-1:CW];

  // Two-bank lexeme store: front writes one bank while back reads the other.
  csl_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_lex_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Back end: expand each job into token words, hold on output stall.
  csl_back #(
    .LEXEME_BUF_LEN(LEXEME_BUF_LEN)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_head),
    .cmd_len_i  (cmd_len_head),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .lex_done_o (lex_done),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .out_o      (out_o)
  );

endmodule

FILE: bench/c_subset_lexer_core_tb.sv
// ----------------------------------------------------------------------------
// c_subset_lexer_core_tb
// Self-checking bench for the C-subset lexer: streams source bytes through the
// valid/ready input channel, predicts every token word in a scoreboard model
// and compares each word that leaves the block, field by field.
// ----------------------------------------------------------------------------
module c_subset_lexer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEX_LEN      = 32;
  localparam int unsigned RANDOM_ITEMS = 250;
  localparam int unsigned IDLE_PCT     = 6;
  // No idling on either side once CALM_FROM bytes have gone in, until CALM_TO have.
  localparam int unsigned CALM_FROM    = 150;
  localparam int unsigned CALM_TO      = 230;
  // Long back-end hold-off, started once the front has taken HOLD_AT bytes.
  localparam int unsigned HOLD_AT      = 80;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } src_byte_t;

  typedef struct packed {
    csl_pkg::csl_kind_e kind;
    logic [7:0]         ch;
    logic               cv;
    logic               te;
    csl_pkg::csl_err_e  err;
    logic               se;
  } token_word_t;

  logic clk_i;
  logic rst_ni;

  csl_in_if  in_if ();
  csl_out_if out_if ();

  c_subset_lexer_core #(
    .LEXEME_BUF_LEN(LEX_LEN)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Source bytes still to offer, and token words still owed by the block.
  src_byte_t   source_q[$];
  token_word_t token_q[$];

  // Scanner copy kept by the bench.
  csl_pkg::csl_mode_e scan_mode = csl_pkg::MODE_IDLE;
  logic [7:0]  lex_chars[LEX_LEN];
  int unsigned lex_len = 0;

  int  n_in = 0;
  int  n_items = 0;
  int  n_fail = 0;
  int  stall_cycles = 0;
  bit  in_took = 1'b0;
  bit  held_once = 1'b0;
  int  hold_left = 0;
  bit  timed_out = 1'b0;
  logic calm;

  assign calm = (n_in >= CALM_FROM) && (n_in < CALM_TO);

  string      single_ops = "+-*/&{}(),;";
  string      pair_ops = "=!<>";
  logic [7:0] blanks[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  logic [7:0] bad_bytes[12] = '{8'h00, 8'h7F, "#", "$", "@", "%", ".", "|", "~", "?",
                                "[", 8'h22};
  string      near_words[10] = '{"return", "if", "for", "int", "in", "fo", "iff", "retur",
                                 "int_", "For"};

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_word(logic [7:0] b);
    return is_digit(b) || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic void emit(csl_pkg::csl_kind_e k, logic [7:0] c, logic cv, logic te,
                               csl_pkg::csl_err_e e);
    token_word_t w;
    w.kind = k;
    w.ch   = c;
    w.cv   = cv;
    w.te   = te;
    w.err  = e;
    w.se   = 1'b0;
    token_q.push_back(w);
  endfunction

  // One-word token: operator or punctuation.
  function automatic void emit_op(csl_pkg::csl_kind_e k);
    emit(k, 8'h00, 1'b0, 1'b1, csl_pkg::ERR_NONE);
  endfunction

  function automatic bit spells(string w);
    if (lex_len != w.len()) return 1'b0;
    for (int i = 0; i < w.len(); i++) begin
      if (lex_chars[i] != w[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Send the buffered lexeme out as a run of character words.
  function automatic void release_lexeme(csl_pkg::csl_kind_e k);
    for (int unsigned i = 0; i < lex_len; i++) begin
      emit(k, lex_chars[i], 1'b1, (i + 1 == lex_len), csl_pkg::ERR_NONE);
    end
    lex_len = 0;
  endfunction

  // Emit whatever token is pending and fall back to idle.
  function automatic void flush_pending();
    csl_pkg::csl_kind_e k;
    case (scan_mode)
      csl_pkg::MODE_NUM: release_lexeme(csl_pkg::TK_INT_LIT);
      csl_pkg::MODE_IDENT: begin
        k = csl_pkg::TK_IDENT;
        if (spells("return")) k = csl_pkg::TK_RETURN;
        else if (spells("if")) k = csl_pkg::TK_IF;
        else if (spells("for")) k = csl_pkg::TK_FOR;
        else if (spells("int")) k = csl_pkg::TK_INT_TYPE;
        release_lexeme(k);
      end
      csl_pkg::MODE_PEQ:  emit_op(csl_pkg::TK_ASSIGN);
      csl_pkg::MODE_PNOT: emit_op(csl_pkg::TK_NOT);
      csl_pkg::MODE_PGT:  emit_op(csl_pkg::TK_GT);
      csl_pkg::MODE_PLT:  emit_op(csl_pkg::TK_LT);
      default: ;
    endcase
    scan_mode = csl_pkg::MODE_IDLE;
    lex_len = 0;
  endfunction

  // Error word carries a zero kind; the scanner then goes dead until reset.
  function automatic void raise_error(csl_pkg::csl_err_e e);
    emit(csl_pkg::TK_ADD, 8'h00, 1'b0, 1'b0, e);
    scan_mode = csl_pkg::MODE_ERR;
    lex_len = 0;
  endfunction

  // Scan one byte from idle.
  function automatic void scan_fresh(logic [7:0] b);
    case (b)
      8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: ;
      "+": emit_op(csl_pkg::TK_ADD);
      "-": emit_op(csl_pkg::TK_SUB);
      "*": emit_op(csl_pkg::TK_MUL);
      "/": emit_op(csl_pkg::TK_DIV);
      "&": emit_op(csl_pkg::TK_AMP);
      "{": emit_op(csl_pkg::TK_LBRACE);
      "}": emit_op(csl_pkg::TK_RBRACE);
      "(": emit_op(csl_pkg::TK_LPAREN);
      ")": emit_op(csl_pkg::TK_RPAREN);
      ",": emit_op(csl_pkg::TK_COMMA);
      ";": emit_op(csl_pkg::TK_SEMI);
      "=": scan_mode = csl_pkg::MODE_PEQ;
      "!": scan_mode = csl_pkg::MODE_PNOT;
      ">": scan_mode = csl_pkg::MODE_PGT;
      "<": scan_mode = csl_pkg::MODE_PLT;
      default: begin
        if (is_word(b)) begin
          lex_chars[0] = b;
          lex_len = 1;
          scan_mode = is_digit(b) ? csl_pkg::MODE_NUM : csl_pkg::MODE_IDENT;
        end else begin
          raise_error(csl_pkg::ERR_UNEXPECTED);
        end
      end
    endcase
  endfunction

  // Advance the model by one accepted byte and queue the words it causes.
  function automatic void scan_byte(logic [7:0] b, logic eoi);
    int unsigned mark;
    bit          more;
    token_word_t last;
    mark = token_q.size();
    if (scan_mode == csl_pkg::MODE_ERR) return;
    if (eoi) begin
      flush_pending();
    end else if (scan_mode == csl_pkg::MODE_NUM || scan_mode == csl_pkg::MODE_IDENT) begin
      more = (scan_mode == csl_pkg::MODE_NUM) ? is_digit(b) : is_word(b);
      if (!more) begin
        flush_pending();
        scan_fresh(b);
      end else if (lex_len >= LEX_LEN - 1) begin
        raise_error(csl_pkg::ERR_TOO_LONG);
      end else begin
        lex_chars[lex_len] = b;
        lex_len++;
      end
    end else if (scan_mode inside {csl_pkg::MODE_PEQ, csl_pkg::MODE_PNOT,
                                   csl_pkg::MODE_PGT, csl_pkg::MODE_PLT}) begin
      if (b == "=") begin
        case (scan_mode)
          csl_pkg::MODE_PEQ:  emit_op(csl_pkg::TK_EQ);
          csl_pkg::MODE_PNOT: emit_op(csl_pkg::TK_NE);
          csl_pkg::MODE_PGT:  emit_op(csl_pkg::TK_GE);
          default:            emit_op(csl_pkg::TK_LE);
        endcase
        scan_mode = csl_pkg::MODE_IDLE;
      end else begin
        flush_pending();
        scan_fresh(b);
      end
    end else begin
      scan_mode = csl_pkg::MODE_IDLE;
      scan_fresh(b);
    end
    // Tag the last word of this step.
    if (token_q.size() > mark) begin
      last = token_q[token_q.size() - 1];
      last.se = 1'b1;
      token_q[token_q.size() - 1] = last;
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_byte(logic [7:0] b);
    source_q.push_back('{ch: b, eoi: 1'b0});
  endfunction

  // End of input; the byte lane is don't-care, so load it with any value.
  function automatic void push_end();
    source_q.push_back('{ch: 8'($urandom_range(0, 255)), eoi: 1'b1});
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  // Letter, '_' or, after the lead character, a digit.
  function automatic logic [7:0] word_char(bit lead);
    int unsigned r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  // Mostly short lexemes, now and then one near or at the buffer limit.
  function automatic int unsigned lexeme_size();
    if ($urandom_range(0, 11) != 0) return $urandom_range(1, 6);
    if ($urandom_range(0, 2) == 0) return LEX_LEN - 1;
    return $urandom_range(20, LEX_LEN - 1);
  endfunction

  function automatic void push_ident(int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_byte(word_char(i == 0));
  endfunction

  function automatic void push_number(int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_byte(8'("0" + $urandom_range(0, 9)));
  endfunction

  // --------------------------------------------------------------------------
  // Source driver: change inputs at the falling edge, hold an offered byte
  // until the block takes it.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : feed
    src_byte_t nxt;
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.in_byte      <= 8'h00;
      in_if.end_of_input <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (source_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = source_q.pop_front();
        in_if.valid        <= 1'b1;
        in_if.in_byte      <= nxt.ch;
        in_if.end_of_input <= nxt.eoi;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Back-end ready: random stalls, plus one long hold-off so that the job
  // queue fills and the block pushes back on the source.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drain
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (!held_once && n_in >= HOLD_AT) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge. Check the outgoing
  // word against the oldest expectation first, then feed the accepted byte
  // to the model, so a word is never matched against its own step.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : sample
    token_word_t want;
    bit          out_took;
    if (rst_ni) begin
      in_took  = in_if.valid && in_if.ready;
      out_took = out_if.valid && out_if.ready;
      if (out_took) begin
        if (token_q.size() == 0) begin
          $error("unexpected token word: kind %0d char 0x%0h err %0d",
                 out_if.tok_kind, out_if.lexeme_char, out_if.error_code);
          n_fail++;
        end else begin
          want = token_q.pop_front();
          check_field("tok_kind", 8'(want.kind), 8'(out_if.tok_kind));
          check_field("lexeme_char", want.ch, out_if.lexeme_char);
          check_field("char_valid", 8'(want.cv), 8'(out_if.char_valid));
          check_field("token_end", 8'(want.te), 8'(out_if.token_end));
          check_field("error_code", 8'(want.err), 8'(out_if.error_code));
          check_field("step_end", 8'(want.se), 8'(out_if.step_end));
        end
      end
      if (in_took) begin
        scan_byte(in_if.in_byte, in_if.end_of_input);
        n_in++;
      end
      stall_cycles = (in_took || out_took) ? 0 : stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : main
    int unsigned n_directed;
    int unsigned pick;
    int unsigned i;
    logic [7:0]  b;

    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.in_byte      = 8'h00;
    in_if.end_of_input = 1'b0;
    out_if.ready       = 1'b0;

    // Directed: every single-character token back to back.
    push_text(single_ops);
    // Keyword and identifiers cut short by the two-character operators,
    // then a literal flushed by end of input.
    push_text("if==_<=Z>=z!=9");
    source_q.push_back('{ch: 8'hFF, eoi: 1'b1});
    // Lone '=', '!', '<', '>' each resolved by a different whitespace byte.
    for (i = 0; i < 4; i++) begin
      push_byte(pair_ops[i]);
      push_byte(blanks[i + 1]);
    end
    push_byte(blanks[5]);
    push_byte(blanks[0]);
    // Pending '<' flushed by end of input; empty flush after it.
    push_byte("<");
    source_q.push_back('{ch: 8'h00, eoi: 1'b1});
    push_end();
    n_directed = source_q.size();

    // Longest lexeme, closed by punctuation: the busiest step of all.
    push_number(LEX_LEN - 1);
    push_byte(";");

    // Random token streams with the odd bit of noise.
    while (source_q.size() < n_directed + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        push_ident(lexeme_size());
      end else if (pick < 42) begin
        push_text(near_words[$urandom_range(0, 9)]);
      end else if (pick < 56) begin
        push_number(lexeme_size());
      end else if (pick < 72) begin
        push_byte(single_ops[$urandom_range(0, 10)]);
      end else if (pick < 88) begin
        push_byte(pair_ops[$urandom_range(0, 3)]);
        if ($urandom_range(0, 1) != 0) push_byte("=");
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 3)) push_byte(blanks[$urandom_range(0, 5)]);
      end else if (pick < 96) begin
        push_end();
      end else begin
        // Noise: any byte the scanner accepts, in any order.
        case ($urandom_range(0, 3))
          0:       push_byte(single_ops[$urandom_range(0, 10)]);
          1:       push_byte(pair_ops[$urandom_range(0, 3)]);
          2:       push_byte(blanks[$urandom_range(0, 5)]);
          default: push_byte(word_char($urandom_range(0, 1)));
        endcase
      end
      if ($urandom_range(0, 9) < 4) push_byte(blanks[$urandom_range(0, 5)]);
    end

    // Close with one of the two errors; the scanner stays dead afterward,
    // so the bytes that follow must produce nothing.
    if ($urandom_range(0, 1) == 0) begin
      push_ident($urandom_range(1, 4));
      b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(128, 255))
                                      : bad_bytes[$urandom_range(0, 11)];
      push_byte(b);
    end else if ($urandom_range(0, 1) == 0) begin
      push_ident(LEX_LEN);
    end else begin
      push_number(LEX_LEN);
    end
    repeat (6) push_byte(8'($urandom_range(0, 255)));
    push_end();
    push_text("int x;");
    n_items = source_q.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every byte to be taken and every word to arrive.
    while (!timed_out && (n_in < n_items || token_q.size() != 0)) begin
      @(negedge clk_i);
      if (stall_cycles >= STALL_LIMIT) timed_out = 1'b1;
    end
    if (!timed_out) repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (!timed_out && n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
design/csl_pkg.sv
design/csl_if.sv
design/csl_ram.sv
design/csl_cmd_fifo.sv
design/csl_front.sv
design/csl_back.sv
design/c_subset_lexer_core.sv
bench/c_subset_lexer_core_tb.sv
